// ===== hdl/vsi_pkg.sv =====
// Package for the velocity setpoint interpolator.
// Holds widths, status and opcode codes, and the controller/datapath command types.
package vsi_pkg;
  localparam int QUEUE_DEPTH = 64;
  localparam int VEL_BITS = 16;
  localparam int IDX_BITS = $clog2(QUEUE_DEPTH);
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
  localparam int STAMP_BITS = 32;
  localparam int VEL_ALL = 4 * VEL_BITS;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_PUSH = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_OVFL = 2'd2;

  typedef struct packed {
    logic                  opcode;
    logic [STAMP_BITS-1:0] now_time;
    logic [STAMP_BITS-1:0] point_stamp;
    logic [VEL_ALL-1:0]    vel;
    logic                  first_of_batch;
    logic                  last_of_batch;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [STAMP_BITS-1:0] stamp;
    logic [VEL_ALL-1:0]    vel;
  } res_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;      // capture the request
    logic batch_open;    // first mark: new batch
    logic hold_cur;      // hold current waypoint
    logic scan_start;    // reset scan index, set key
    logic scan_step;     // advance scan index
    logic key_held;      // scan key is held stamp (else point stamp / now)
    logic trunc;         // truncate queue at scan index
    logic app_held;      // append held waypoint
    logic app_cur;       // append current waypoint
    logic set_emitted;   // batch emitted, held cleared
    logic trim;          // drop stale head entries
    logic rd0;           // read entry at head
    logic rd1;           // read entry at head+1
    logic div_start;     // start the dividers
    logic res_single;    // result: single entry
    logic res_interp;    // result: interpolation
    logic res_fail;      // result: failure
    logic res_push;      // result: push status
  } cmd_t;

  typedef struct packed {
    logic is_push;
    logic first;
    logic last;
    logic emitted;
    logic held_valid;
    logic below_batch;   // point stamp < batch time (after update)
    logic scan_done;     // scan index reached count
    logic scan_hit;      // entry at scan index: stamp >= key
    logic scan_wait;     // read data for the scan index not yet available
    logic full;
    logic cnt_zero;
    logic cnt_one;
    logic span_bad;
    logic div_done;
  } sts_t;
endpackage

// ===== hdl/vsi_if.sv =====
// Valid/ready channel interface for requests and results.
// Depends on nothing; payload type is a parameter of the interface.
interface vsi_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/velocity_setpoint_interpolator.sv =====
// Top level of the velocity setpoint interpolator.
// Depends on vsi_pkg, vsi_if, vsi_ctrl and vsi_dp.
//
// One request is taken at a time and gives one result. A push that only holds its
// waypoint goes from decode straight to the result; one that is appended directly
// passes through the append state first; a push that truncates the queue scans it
// entry by entry through a registered queue read, waiting for each read to land.
// A query scans the stale head entries the same way, trims them, reads the first two
// entries, and when it interpolates runs the bit-serial divider, which makes one
// quotient bit a cycle. The result is held until taken, after which the next request
// is accepted.
module velocity_setpoint_interpolator import vsi_pkg::*; (
  input logic clk,
  input logic rst_n,
  vsi_if.sink   in_ch,
  vsi_if.source out_ch
);
  cmd_t cmd;
  sts_t sts;
  req_t req;
  res_t res;

  assign req = in_ch.data;
  assign out_ch.data = res;

  vsi_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts(sts), .cmd(cmd)
  );

  vsi_dp u_dp (
    .clk(clk), .rst_n(rst_n), .req(req), .cmd(cmd), .sts(sts), .res(res)
  );

  // A request is never taken while a result is waiting.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("request accepted with result pending");
  // An accepted request leaves the controller busy in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("controller not busy");
endmodule

// ===== hdl/vsi_ctrl.sv =====
// Controller state machine of the velocity setpoint interpolator.
// Depends on vsi_pkg; drives cmd_t to vsi_dp and reads sts_t back.
module vsi_ctrl import vsi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_DEC = 4'd1, S_SCAN = 4'd2, S_TRUNC = 4'd3,
    S_APH = 4'd4, S_APC = 4'd5, S_QSCAN = 4'd6, S_QTRIM = 4'd7, S_QRD = 4'd8,
    S_QCHK = 4'd9, S_DIV = 4'd10, S_DONE = 4'd11, S_OUT = 4'd12, S_QRD1 = 4'd13,
    S_QWAIT = 4'd14;

  logic [3:0] state_r, state_nxt;
  logic       held_path_r, held_path_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_path_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_path_r <= held_path_nxt;
    end
  end

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    held_path_nxt = held_path_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.is_push) begin
          if (sts.first) cmd.batch_open = 1'b1;
          // Decision uses the post-batch-open view supplied by the datapath.
          if (sts.emitted && !sts.first) begin
            state_nxt = S_APC;
          end else if (sts.below_batch) begin
            cmd.hold_cur = 1'b1;
            if (sts.last) begin
              cmd.scan_start = 1'b1;
              cmd.key_held = 1'b0;
              held_path_nxt = 1'b1;
              state_nxt = S_SCAN;
            end else begin
              cmd.res_push = 1'b1;
              state_nxt = S_OUT;
            end
          end else begin
            cmd.scan_start = 1'b1;
            cmd.key_held = sts.held_valid && !sts.first;
            held_path_nxt = sts.held_valid && !sts.first;
            state_nxt = S_SCAN;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_nxt = sts.cnt_zero ? S_DONE : S_QSCAN;
        end
      end
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_APH;
        else if (!sts.scan_wait) begin
          if (sts.scan_hit) begin
            cmd.trunc = 1'b1;
            state_nxt = S_APH;
          end else cmd.scan_step = 1'b1;
        end
      end
      S_TRUNC: state_nxt = S_APH;
      S_APH: begin
        if (held_path_r) cmd.app_held = 1'b1;
        state_nxt = S_APC;
      end
      S_APC: begin
        // On the held-only path (last below batch time) the held entry was the waypoint.
        if (!(held_path_r && sts.below_batch)) cmd.app_cur = 1'b1;
        cmd.set_emitted = 1'b1;
        cmd.res_push = 1'b1;
        held_path_nxt = 1'b0;
        state_nxt = S_OUT;
      end
      S_QSCAN: begin
        if (sts.scan_done || (!sts.scan_wait && sts.scan_hit)) state_nxt = S_QTRIM;
        else if (!sts.scan_wait) cmd.scan_step = 1'b1;
      end
      S_QTRIM: begin
        cmd.trim = 1'b1;
        state_nxt = S_QRD;
      end
      S_QRD: begin
        cmd.rd0 = 1'b1;
        state_nxt = S_QRD1;
      end
      S_QRD1: begin
        cmd.rd1 = 1'b1;
        state_nxt = S_QWAIT;
      end
      // The second entry lands in the datapath at the end of this cycle.
      S_QWAIT: state_nxt = S_QCHK;
      S_QCHK: begin
        if (sts.cnt_one) begin
          cmd.res_single = 1'b1;
          state_nxt = S_OUT;
        end else if (sts.span_bad) begin
          cmd.res_fail = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.res_interp = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_DONE: begin
        cmd.res_fail = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

// ===== hdl/vsi_dp.sv =====
// Datapath of the velocity setpoint interpolator: queue memory, batch state,
// scan index and a bit-serial divider per velocity lane. Depends on vsi_pkg.
module vsi_dp import vsi_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output res_t res
);
  localparam int MAG_BITS = VEL_BITS + 1;
  localparam int PROD_BITS = MAG_BITS + STAMP_BITS;
  localparam int DCNT_BITS = $clog2(PROD_BITS + 1);

  logic [STAMP_BITS-1:0] stamp_mem [QUEUE_DEPTH];
  logic [VEL_ALL-1:0]    vel_mem [QUEUE_DEPTH];

  req_t                  req_r;
  logic [IDX_BITS-1:0]   head_r;
  logic [CNT_BITS-1:0]   count_r, count_nxt;
  logic [STAMP_BITS-1:0] held_stamp_r;
  logic [VEL_ALL-1:0]    held_vel_r;
  logic                  held_valid_r, emitted_r;
  logic [STAMP_BITS-1:0] batch_time_r;
  logic [CNT_BITS-1:0]   scan_r;
  logic [STAMP_BITS-1:0] key_r;
  logic                  z0_r;      // entry zero still holds its reset value
  logic [STAMP_BITS-1:0] rd_stamp_r, b_stamp_r, e_stamp_r;
  logic [VEL_ALL-1:0]    rd_vel_r, b_vel_r, e_vel_r;
  logic [STAMP_BITS-1:0] scan_rd_r;
  logic                  scan_z0_r, scan_ok_r;
  res_t                  res_r;

  logic [STAMP_BITS-1:0] batch_eff;
  logic [IDX_BITS-1:0]   scan_slot, app_slot, rd_slot;
  logic [STAMP_BITS-1:0] scan_stamp;
  logic                  app_en;
  logic [STAMP_BITS-1:0] app_stamp;
  logic [VEL_ALL-1:0]    app_vel;

  function automatic logic [IDX_BITS-1:0] wrap(input logic [CNT_BITS:0] v);
    logic [CNT_BITS:0] t;
    begin
      t = (v >= (CNT_BITS+1)'(QUEUE_DEPTH)) ? v - (CNT_BITS+1)'(QUEUE_DEPTH) : v;
      wrap = t[IDX_BITS-1:0];
    end
  endfunction

  assign batch_eff = req_r.first_of_batch ? req_r.now_time : batch_time_r;
  assign scan_slot = wrap({1'b0, CNT_BITS'(head_r)} + {1'b0, scan_r});
  assign app_slot = wrap({1'b0, CNT_BITS'(head_r)} + {1'b0, count_r});
  assign rd_slot = wrap({1'b0, CNT_BITS'(head_r)} + {{CNT_BITS{1'b0}}, cmd.rd1});

  // Registered read for the scan; entry zero reads as zero until first written.
  // The data for a new scan index is valid in the cycle after the index moves.
  assign scan_stamp = scan_z0_r ? '0 : scan_rd_r;

  assign app_en = (cmd.app_held || cmd.app_cur) && (count_r < CNT_BITS'(QUEUE_DEPTH));
  assign app_stamp = cmd.app_held ? held_stamp_r : req_r.point_stamp;
  assign app_vel = cmd.app_held ? held_vel_r : req_r.vel;

  always_ff @(posedge clk) begin
    if (app_en) begin
      stamp_mem[app_slot] <= app_stamp;
      vel_mem[app_slot] <= app_vel;
    end
    rd_stamp_r <= stamp_mem[rd_slot];
    rd_vel_r <= vel_mem[rd_slot];
    scan_rd_r <= stamp_mem[scan_slot];
  end

  // Read data of the two entries: rd0 lands in b, rd1 in e.
  logic rd0_d_r, rd1_d_r, z0_rd_r;
  logic [STAMP_BITS-1:0] rd_fix_stamp;
  logic [VEL_ALL-1:0]    rd_fix_vel;
  assign rd_fix_stamp = z0_rd_r ? '0 : rd_stamp_r;
  assign rd_fix_vel = z0_rd_r ? '0 : rd_vel_r;

  always_comb begin
    count_nxt = count_r;
    if (cmd.trunc) count_nxt = scan_r;
    if (cmd.trim && scan_r > CNT_BITS'(1)) count_nxt = count_r - scan_r + CNT_BITS'(1);
    if (app_en) count_nxt = count_r + CNT_BITS'(1);
  end

  // Lane dividers: mag * dt / span by restoring long division, one bit a cycle.
  logic [STAMP_BITS-1:0] span_r, dt_r;
  logic [DCNT_BITS-1:0]  dcnt_r;
  logic                  dbusy_r;
  logic [PROD_BITS-1:0]  prod_r [4];
  logic [PROD_BITS-1:0]  quo_r [4];
  logic [STAMP_BITS:0]   rem_r [4];
  logic                  neg_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      count_r <= CNT_BITS'(1);
      held_valid_r <= 1'b0;
      emitted_r <= 1'b0;
      batch_time_r <= '0;
      held_stamp_r <= '0;
      held_vel_r <= '0;
      z0_r <= 1'b1;
      dbusy_r <= 1'b0;
      rd0_d_r <= 1'b0;
      rd1_d_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rd0_d_r <= cmd.rd0;
      rd1_d_r <= cmd.rd1;
      if (app_en && app_slot == '0) z0_r <= 1'b0;
      if (cmd.batch_open) begin
        batch_time_r <= req_r.now_time;
        emitted_r <= 1'b0;
      end
      if (cmd.hold_cur) begin
        held_stamp_r <= req_r.point_stamp;
        held_vel_r <= req_r.vel;
      end
      // A waypoint held in the same cycle as a batch opens stays held.
      if (cmd.hold_cur) held_valid_r <= 1'b1;
      else if (cmd.batch_open || cmd.set_emitted) held_valid_r <= 1'b0;
      if (cmd.set_emitted) emitted_r <= 1'b1;
      if (cmd.trim && scan_r > CNT_BITS'(1))
        head_r <= wrap({1'b0, CNT_BITS'(head_r)} + {1'b0, scan_r} - (CNT_BITS+1)'(1));
      if (cmd.div_start) dbusy_r <= 1'b1;
      else if (dbusy_r && dcnt_r == '0) dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) req_r <= req;
    z0_rd_r <= z0_r && rd_slot == '0;
    scan_z0_r <= z0_r && scan_slot == '0;
    scan_ok_r <= !(cmd.scan_start || cmd.scan_step);
    if (rd0_d_r) begin
      b_stamp_r <= rd_fix_stamp;
      b_vel_r <= rd_fix_vel;
    end
    if (rd1_d_r) begin
      e_stamp_r <= rd_fix_stamp;
      e_vel_r <= rd_fix_vel;
    end
    if (cmd.scan_start) begin
      scan_r <= '0;
      if (!req_r.opcode) key_r <= req_r.now_time;
      else if (cmd.key_held) key_r <= held_stamp_r;
      else key_r <= req_r.point_stamp;
    end else if (cmd.scan_step) scan_r <= scan_r + CNT_BITS'(1);
  end

  // Query scan compares stamp < now; push scan compares stamp >= key: same test.
  assign sts.is_push = req_r.opcode == OP_PUSH;
  assign sts.first = req_r.first_of_batch;
  assign sts.last = req_r.last_of_batch;
  assign sts.emitted = emitted_r;
  assign sts.held_valid = held_valid_r;
  assign sts.below_batch = req_r.point_stamp < batch_eff;
  assign sts.scan_done = scan_r >= count_r;
  assign sts.scan_hit = scan_stamp >= key_r;
  assign sts.scan_wait = !scan_ok_r;
  assign sts.full = count_r >= CNT_BITS'(QUEUE_DEPTH);
  assign sts.cnt_zero = count_r == '0;
  assign sts.cnt_one = count_r == CNT_BITS'(1);
  assign sts.span_bad = (e_stamp_r < b_stamp_r) || (req_r.now_time > e_stamp_r) ||
                        (req_r.now_time < b_stamp_r);
  assign sts.div_done = dbusy_r && dcnt_r == '0;

  for (genvar g = 0; g < 4; g++) begin : g_lane
    logic signed [VEL_BITS-1:0] bv, ev;
    logic signed [MAG_BITS-1:0] diff;
    logic [MAG_BITS-1:0]        mag;
    logic [STAMP_BITS:0]        rsh;
    assign bv = b_vel_r[g*VEL_BITS +: VEL_BITS];
    assign ev = e_vel_r[g*VEL_BITS +: VEL_BITS];
    assign diff = MAG_BITS'(ev) - MAG_BITS'(bv);
    assign mag = diff[MAG_BITS-1] ? MAG_BITS'(-diff) : MAG_BITS'(diff);
    assign rsh = {rem_r[g][STAMP_BITS-1:0], prod_r[g][PROD_BITS-1]};

    always_ff @(posedge clk) begin
      if (cmd.div_start) begin
        neg_r[g] <= diff[MAG_BITS-1];
        rem_r[g] <= '0;
        quo_r[g] <= '0;
        // Product formed first, one multiplier per lane, registered.
        prod_r[g] <= PROD_BITS'(mag) * PROD_BITS'(req_r.now_time - b_stamp_r);
      end else if (dbusy_r) begin
        prod_r[g] <= {prod_r[g][PROD_BITS-2:0], 1'b0};
        if (rsh >= {1'b0, span_r}) begin
          rem_r[g] <= rsh - {1'b0, span_r};
          quo_r[g] <= {quo_r[g][PROD_BITS-2:0], 1'b1};
        end else begin
          rem_r[g] <= rsh;
          quo_r[g] <= {quo_r[g][PROD_BITS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      span_r <= e_stamp_r - b_stamp_r;
      dt_r <= req_r.now_time - b_stamp_r;
      dcnt_r <= DCNT_BITS'(PROD_BITS);
    end else if (dbusy_r && dcnt_r != '0) dcnt_r <= dcnt_r - DCNT_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.res_push) begin
      res_r.status <= (app_en || !(cmd.app_held || cmd.app_cur) && res_r.status != ST_OVFL)
                      ? res_r.status : ST_OVFL;
      res_r.stamp <= '0;
      res_r.vel <= '0;
    end else if (cmd.res_single) begin
      res_r.status <= ST_OK;
      res_r.stamp <= b_stamp_r;
      res_r.vel <= b_vel_r;
    end else if (cmd.res_fail) begin
      res_r.status <= ST_FAIL;
      res_r.stamp <= '0;
      res_r.vel <= '0;
    end else if (cmd.res_interp) begin
      res_r.status <= ST_OK;
      res_r.stamp <= req_r.now_time;
      for (int k = 0; k < 4; k++) begin
        if (span_r == '0 || dt_r == '0)
          res_r.vel[k*VEL_BITS +: VEL_BITS] <= b_vel_r[k*VEL_BITS +: VEL_BITS];
        else if (neg_r[k])
          res_r.vel[k*VEL_BITS +: VEL_BITS] <= b_vel_r[k*VEL_BITS +: VEL_BITS]
                                               - quo_r[k][VEL_BITS-1:0];
        else
          res_r.vel[k*VEL_BITS +: VEL_BITS] <= b_vel_r[k*VEL_BITS +: VEL_BITS]
                                               + quo_r[k][VEL_BITS-1:0];
      end
    end else if (cmd.load_req) begin
      res_r.status <= ST_OK;
    end else if ((cmd.app_held || cmd.app_cur) && !app_en) begin
      res_r.status <= ST_OVFL;
    end
  end

  assign res = res_r;
endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for velocity_setpoint_interpolator.
// Depends on vsi_pkg, vsi_if and the RTL top; predicts every result in a small scoreboard.
`timescale 1ns / 1ps

module tb;
  import vsi_pkg::*;

  class setpoint_scoreboard;
    bit [31:0]  stamp_q [QUEUE_DEPTH];
    longint     vel_q [QUEUE_DEPTH][4];
    int         head, count;
    bit [31:0]  held_stamp, batch_time;
    longint     held_vel [4];
    bit         held_valid, emitted;
    res_t       expected [$];
    int         errors;

    function new();
      head = 0;
      count = 1;
      stamp_q[0] = 0;
      for (int j = 0; j < 4; j++) begin
        vel_q[0][j] = 0;
        held_vel[j] = 0;
      end
      held_stamp = 0;
      batch_time = 0;
      held_valid = 0;
      emitted = 0;
      errors = 0;
    endfunction

    function int slot(int i);
      return (head + i) % QUEUE_DEPTH;
    endfunction

    function void cut_from(bit [31:0] key);
      for (int i = 0; i < count; i++) begin
        if (stamp_q[slot(i)] >= key) begin
          count = i;
          return;
        end
      end
    endfunction

    function bit push_entry(bit [31:0] s, longint v [4]);
      int k;
      if (count >= QUEUE_DEPTH) return 0;
      k = slot(count);
      stamp_q[k] = s;
      for (int j = 0; j < 4; j++) vel_q[k][j] = v[j];
      count++;
      return 1;
    endfunction

    function longint blend(longint b, longint e, longint unsigned dt,
                           longint unsigned span);
      longint diff;
      longint unsigned mag;
      longint inc;
      diff = e - b;
      mag = diff < 0 ? longint'(-diff) : diff;
      inc = longint'((mag * dt) / span);
      return diff < 0 ? b - inc : b + inc;
    endfunction

    function void note(req_t r);
      res_t    x;
      longint  v [4];
      bit      ok;
      int      i, s0, s1;
      bit [31:0] b, e;
      x = '0;
      ok = 1;
      if (r.opcode == OP_PUSH) begin
        for (int j = 0; j < 4; j++)
          v[j] = longint'($signed(r.vel[j*VEL_BITS +: VEL_BITS]));
        if (r.first_of_batch) begin
          batch_time = r.now_time;
          emitted = 0;
          held_valid = 0;
        end
        if (emitted) begin
          ok = push_entry(r.point_stamp, v);
        end else if (r.point_stamp < batch_time) begin
          held_stamp = r.point_stamp;
          held_vel = v;
          held_valid = 1;
          if (r.last_of_batch) begin
            cut_from(held_stamp);
            ok = push_entry(held_stamp, held_vel);
            emitted = 1;
            held_valid = 0;
          end
        end else begin
          cut_from(held_valid ? held_stamp : r.point_stamp);
          if (held_valid && !push_entry(held_stamp, held_vel)) ok = 0;
          if (!push_entry(r.point_stamp, v)) ok = 0;
          emitted = 1;
          held_valid = 0;
        end
        x.status = ok ? ST_OK : ST_OVFL;
      end else if (count == 0) begin
        x.status = ST_FAIL;
      end else begin
        i = 0;
        while (i < count && stamp_q[slot(i)] < r.now_time) i++;
        if (i > 1) begin
          head = slot(i - 1);
          count -= i - 1;
        end
        s0 = slot(0);
        s1 = slot(1);
        if (count == 1) begin
          x.stamp = stamp_q[s0];
          for (int j = 0; j < 4; j++) x.vel[j*VEL_BITS +: VEL_BITS] = vel_q[s0][j];
        end else begin
          b = stamp_q[s0];
          e = stamp_q[s1];
          if (e < b || r.now_time > e || r.now_time < b) begin
            x.status = ST_FAIL;
          end else begin
            x.stamp = r.now_time;
            for (int j = 0; j < 4; j++) begin
              v[j] = vel_q[s0][j];
              if (e != b) v[j] = blend(v[j], vel_q[s1][j], r.now_time - b, e - b);
              x.vel[j*VEL_BITS +: VEL_BITS] = v[j];
            end
          end
        end
      end
      expected.push_back(x);
    endfunction

    function void check(res_t got);
      res_t want;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.stamp !== want.stamp) begin
        errors++;
        $display("%0t: stamp expected %h actual %h", $time, want.stamp, got.stamp);
      end
      for (int j = 0; j < 4; j++) begin
        if (got.vel[j*VEL_BITS +: VEL_BITS] !== want.vel[j*VEL_BITS +: VEL_BITS]) begin
          errors++;
          $display("%0t: velocity lane %0d expected %h actual %h", $time, j,
                   want.vel[j*VEL_BITS +: VEL_BITS], got.vel[j*VEL_BITS +: VEL_BITS]);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  always #6 clk = ~clk;

  vsi_if #(.payload_t(req_t)) in_ch (clk);
  vsi_if #(.payload_t(res_t)) out_ch (clk);

  velocity_setpoint_interpolator i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  setpoint_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  int  recv_hold = 0;
  int  cycles = 0;
  bit [31:0] tbase;

  initial begin
    in_ch.valid = 0;
    in_ch.data = '0;
    out_ch.ready = 0;
  end

  always @(posedge clk) begin
    if (recv_hold > 0) begin
      out_ch.ready <= 0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
    if (rst_n && out_ch.valid && out_ch.ready) sb.check(out_ch.data);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 1500000) begin
      $display("velocity_setpoint_interpolator verification failed");
      $finish;
    end
  end

  function automatic req_t make_req(bit op, bit [31:0] now, bit [31:0] st, bit fst,
                                    bit lst);
    req_t r;
    r.opcode = op;
    r.now_time = now;
    r.point_stamp = st;
    r.vel = {$urandom, $urandom};
    r.first_of_batch = fst;
    r.last_of_batch = lst;
    return r;
  endfunction

  // Offers one request, holding valid until it is taken, then idles at random.
  task automatic send(req_t r);
    in_ch.valid <= 1;
    in_ch.data <= r;
    do @(posedge clk); while (!in_ch.ready);
    sb.note(r);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    while (sb.expected.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic random_batch();
    int n, gap;
    bit [31:0] st;
    n = $urandom_range(1, 6);
    st = tbase - $urandom_range(0, 3) * 400;
    for (int k = 0; k < n; k++) begin
      send(make_req(OP_PUSH, tbase, st, k == 0, k == n - 1));
      gap = $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 1500);
      st = ($urandom_range(0, 19) == 0) ? st - gap : st + gap;
    end
  endtask

  task automatic random_phase(int items);
    int sent;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          random_batch();
          sent += 3;
        end
        3: begin
          // Noise: fully random fields, including stray marks and raw stamps.
          send(make_req($urandom_range(0, 1), $urandom, $urandom, $urandom_range(0, 1),
                        $urandom_range(0, 1)));
          sent++;
        end
        default: begin
          send(make_req(OP_QUERY, tbase + $urandom_range(0, 3000) - 500, $urandom,
                        $urandom_range(0, 1), $urandom_range(0, 1)));
          tbase += $urandom_range(0, 300);
          sent++;
        end
      endcase
    end
  endtask

  initial begin
    tbase = $urandom_range(10000, 32'h7fff_0000);
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Query straight after reset returns the initial zero entry.
    send(make_req(OP_QUERY, 32'hffff_ffff, 0, 0, 0));
    // Batch opened, waypoint before arrival held, then a later one appended.
    send(make_req(OP_PUSH, 1000, 500, 1, 0));
    send(make_req(OP_PUSH, 1000, 2000, 0, 1));
    send(make_req(OP_QUERY, 1250, 0, 0, 0));
    send(make_req(OP_QUERY, 3000, 0, 0, 0));
    // Zero span: two entries with the same stamp.
    send(make_req(OP_PUSH, 5000, 5000, 1, 0));
    send(make_req(OP_PUSH, 5000, 5000, 0, 1));
    send(make_req(OP_QUERY, 5000, 0, 0, 0));
    // Before the span, then a held waypoint closed on its own.
    send(make_req(OP_QUERY, 10, 0, 0, 0));
    send(make_req(OP_PUSH, 9000, 8000, 1, 1));
    // First mark while a batch is still open discards the held waypoint.
    send(make_req(OP_PUSH, 20000, 19000, 1, 0));
    send(make_req(OP_PUSH, 30000, 29000, 1, 0));
    send(make_req(OP_PUSH, 30000, 32'hffff_ffff, 0, 1));
    send(make_req(OP_QUERY, 32'hffff_fff0, 0, 0, 0));
    // Unsorted tail appended after the batch closed.
    send(make_req(OP_PUSH, 0, 100, 0, 0));
    send(make_req(OP_QUERY, 50, 0, 0, 0));
    // Fill the queue until waypoints overflow.
    send(make_req(OP_PUSH, 0, 0, 1, 0));
    for (int k = 1; k < QUEUE_DEPTH + 4; k++) send(make_req(OP_PUSH, 0, k * 10, 0, 0));
    send(make_req(OP_QUERY, 15, 0, 0, 0));
    send(make_req(OP_QUERY, 32'hffff_ffff, 0, 0, 0));
    drain();

    send_idle_pct = 17;
    recv_idle_pct = 70;
    random_phase(200);
    // Long receiver stall while requests keep coming.
    recv_hold = 500;
    random_phase(230);
    // Sender waits for every outstanding result.
    drain();
    send_idle_pct = 70;
    recv_idle_pct = 17;
    random_phase(430);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(430);
    drain();

    if (sb.errors == 0) begin
      $display("velocity_setpoint_interpolator verification clean");
    end else begin
      $display("velocity_setpoint_interpolator verification failed");
    end
    $finish;
  end
endmodule
